// File: hdl/bpsc_pkg.sv
// package: widths and flag positions for the box plane side classifier
`timescale 1ns / 1ps

package bpsc_pkg;

  localparam int COORD_W  = 32;                  // q16.16 coordinates and distance
  localparam int NORMAL_W = 18;                  // q1.16 normal components
  localparam int FRAC_SHIFT = 16;                // aligns q16.16 with q17.32
  localparam int PROD_W   = COORD_W + NORMAL_W;  // exact product width
  localparam int SUM_W    = PROD_W + 2;          // exact three-term sum width
  localparam int AXES     = 3;
  localparam int FLAGS_W  = 2;

  localparam int FRONT_BIT = 0;
  localparam int BACK_BIT  = 1;

  typedef logic signed [COORD_W-1:0]  coord_t;
  typedef logic signed [NORMAL_W-1:0] normal_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [SUM_W-1:0]    sum_t;

endpackage

// File: hdl/box_plane_side_classifier_top.sv
// top level: pipelined box against plane side classifier
`timescale 1ns / 1ps

// channel  | ports                                   | handshake
// ---------+-----------------------------------------+---------------------------------
// input    | in_box_min_*, in_box_max_*, in_normal_*,| taken when start high, busy low
//          | in_plane_dist, in_sign_bits             |
// result   | out_side_flags                          | out_valid for one cycle, no stall
//
// four register stages: corner select, six multiplies, sums and limit, compare
// one item can enter every cycle; out_valid rises once the item has passed the corner select,
// multiply, sum and compare registers
// busy never rises since the receiver cannot hold results off and nothing blocks
// rst_n (synchronous, active low) clears the valid bits only; payload is not reset

module box_plane_side_classifier_top
  import bpsc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [COORD_W-1:0]  in_box_min_x,
  input  logic [COORD_W-1:0]  in_box_min_y,
  input  logic [COORD_W-1:0]  in_box_min_z,
  input  logic [COORD_W-1:0]  in_box_max_x,
  input  logic [COORD_W-1:0]  in_box_max_y,
  input  logic [COORD_W-1:0]  in_box_max_z,
  input  logic [NORMAL_W-1:0] in_normal_x,
  input  logic [NORMAL_W-1:0] in_normal_y,
  input  logic [NORMAL_W-1:0] in_normal_z,
  input  logic [COORD_W-1:0]  in_plane_dist,
  input  logic [AXES-1:0]     in_sign_bits,
  output logic                out_valid,
  output logic [FLAGS_W-1:0]  out_side_flags
);

  // pipeline never stalls
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // ---------------------------------------------------------------------------
  // stage 1: pick near and far corner coordinate per axis
  // ---------------------------------------------------------------------------
  coord_t  lo_c[AXES];
  coord_t  hi_c[AXES];
  normal_t nrm_c[AXES];

  assign lo_c[0]  = coord_t'(in_box_min_x);
  assign lo_c[1]  = coord_t'(in_box_min_y);
  assign lo_c[2]  = coord_t'(in_box_min_z);
  assign hi_c[0]  = coord_t'(in_box_max_x);
  assign hi_c[1]  = coord_t'(in_box_max_y);
  assign hi_c[2]  = coord_t'(in_box_max_z);
  assign nrm_c[0] = normal_t'(in_normal_x);
  assign nrm_c[1] = normal_t'(in_normal_y);
  assign nrm_c[2] = normal_t'(in_normal_z);

  logic    s1_valid_r, s1_valid_nxt;
  coord_t  s1_near_r[AXES], s1_near_nxt[AXES];
  coord_t  s1_far_r[AXES],  s1_far_nxt[AXES];
  normal_t s1_nrm_r[AXES];
  coord_t  s1_dist_r;

  always_comb begin
    s1_valid_nxt = accept;
    for (int i = 0; i < AXES; i++) begin
      // sign bit set: near sum takes the minimum, far sum the maximum
      if (in_sign_bits[i]) begin
        s1_near_nxt[i] = lo_c[i];
        s1_far_nxt[i]  = hi_c[i];
      end else begin
        s1_near_nxt[i] = hi_c[i];
        s1_far_nxt[i]  = lo_c[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < AXES; i++) begin
      s1_near_r[i] <= s1_near_nxt[i];
      s1_far_r[i]  <= s1_far_nxt[i];
      s1_nrm_r[i]  <= nrm_c[i];
    end
    s1_dist_r <= coord_t'(in_plane_dist);
  end

  // ---------------------------------------------------------------------------
  // stage 2: six exact 32 x 18 signed products
  // ---------------------------------------------------------------------------
  logic   s2_valid_r;
  prod_t  s2_near_p_r[AXES], s2_near_p_nxt[AXES];
  prod_t  s2_far_p_r[AXES],  s2_far_p_nxt[AXES];
  coord_t s2_dist_r;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      s2_near_p_nxt[i] = prod_t'(s1_near_r[i]) * prod_t'(s1_nrm_r[i]);
      s2_far_p_nxt[i]  = prod_t'(s1_far_r[i])  * prod_t'(s1_nrm_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < AXES; i++) begin
      s2_near_p_r[i] <= s2_near_p_nxt[i];
      s2_far_p_r[i]  <= s2_far_p_nxt[i];
    end
    s2_dist_r <= s1_dist_r;
  end

  // ---------------------------------------------------------------------------
  // stage 3: three-term sums and the plane distance on the product scale
  // ---------------------------------------------------------------------------
  logic s3_valid_r;
  sum_t s3_near_sum_r, s3_near_sum_nxt;
  sum_t s3_far_sum_r,  s3_far_sum_nxt;
  sum_t s3_limit_r,    s3_limit_nxt;

  always_comb begin
    s3_near_sum_nxt = sum_t'(s2_near_p_r[0]) + sum_t'(s2_near_p_r[1])
                    + sum_t'(s2_near_p_r[2]);
    s3_far_sum_nxt  = sum_t'(s2_far_p_r[0]) + sum_t'(s2_far_p_r[1])
                    + sum_t'(s2_far_p_r[2]);
    // q16.16 distance shifted up to 32 fraction bits, sign extended
    s3_limit_nxt    = {{(SUM_W-COORD_W-FRAC_SHIFT){s2_dist_r[COORD_W-1]}},
                       s2_dist_r, {FRAC_SHIFT{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_near_sum_r <= s3_near_sum_nxt;
    s3_far_sum_r  <= s3_far_sum_nxt;
    s3_limit_r    <= s3_limit_nxt;
  end

  // ---------------------------------------------------------------------------
  // stage 4: compare against the plane and register the result
  // ---------------------------------------------------------------------------
  logic               out_valid_r;
  logic [FLAGS_W-1:0] out_flags_r, out_flags_nxt;

  always_comb begin
    out_flags_nxt            = '0;
    out_flags_nxt[FRONT_BIT] = (s3_near_sum_r >= s3_limit_r);  // reaches front side
    out_flags_nxt[BACK_BIT]  = (s3_far_sum_r < s3_limit_r);    // reaches back side
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_flags_r <= out_flags_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_side_flags = out_flags_r;

endmodule

// File: bench/tb_box_plane_side_classifier_top.sv
// testbench: random and directed check of the box plane side classifier top level
`timescale 1ns / 1ps

// drives boxes and planes into the classifier and compares every side flag pair
// against a fixed-point predictor kept inside a small scoreboard class
//
// - the input side raises start and holds an item until an edge with busy low
// - every accepted item is noted at that edge and its expected flags are queued
// - out_valid marks one result per item; it is checked against the oldest entry
// - directed items cover zero, unit boxes under all eight corner choices,
//   extreme coordinates, normals outside the unit range, minimum above maximum,
//   and sums that land exactly on the plane distance
// - random items are mostly well-formed boxes with the plane placed near the
//   projected corners, the rest are swapped corners, odd sign bits and raw noise

module tb_box_plane_side_classifier_top;
  import bpsc_pkg::*;

  localparam int LATENCY     = 3;    // part of the final drain wait
  localparam int IDLE_LIMIT  = 500;  // watchdog: cycles with nothing accepted and no result
  localparam int N_RANDOM    = 950;
  localparam int CALM_TAIL   = 150;  // last items go without input gaps

  localparam coord_t  C_MAX = 32'sh7fff_ffff;
  localparam coord_t  C_MIN = 32'sh8000_0000;
  localparam coord_t  C_ONE = 32'sh0001_0000;  // 1.0 in q16.16
  localparam normal_t N_ONE = 18'sh1_0000;     // 1.0 in q1.16
  localparam normal_t N_MAX = 18'sh1_ffff;     // beyond +1.0
  localparam normal_t N_MIN = 18'sh2_0000;     // beyond -1.0

  typedef struct packed {
    coord_t            min_x;
    coord_t            min_y;
    coord_t            min_z;
    coord_t            max_x;
    coord_t            max_y;
    coord_t            max_z;
    normal_t           nx;
    normal_t           ny;
    normal_t           nz;
    coord_t            plane_dist;
    logic [AXES-1:0]   sign_bits;
  } box_t;

  // expected side flags in arrival order, worked out from each accepted box
  class side_flag_ledger;
    logic [FLAGS_W-1:0] pending_flags[$];
    int                 mismatches;

    function new();
      mismatches = 0;
    endfunction

    // exact dot products: q16.16 times q1.16 fits easily in 64 bits
    function logic [FLAGS_W-1:0] classify(box_t b);
      longint             lo[AXES];
      longint             hi[AXES];
      longint             nv[AXES];
      longint             near_acc;
      longint             far_acc;
      longint             limit;
      logic [FLAGS_W-1:0] flags;
      lo[0] = longint'($signed(b.min_x));
      lo[1] = longint'($signed(b.min_y));
      lo[2] = longint'($signed(b.min_z));
      hi[0] = longint'($signed(b.max_x));
      hi[1] = longint'($signed(b.max_y));
      hi[2] = longint'($signed(b.max_z));
      nv[0] = longint'($signed(b.nx));
      nv[1] = longint'($signed(b.ny));
      nv[2] = longint'($signed(b.nz));
      near_acc = 0;
      far_acc  = 0;
      for (int i = 0; i < AXES; i++) begin
        if (b.sign_bits[i]) begin
          near_acc += nv[i] * lo[i];
          far_acc  += nv[i] * hi[i];
        end else begin
          near_acc += nv[i] * hi[i];
          far_acc  += nv[i] * lo[i];
        end
      end
      limit = longint'($signed(b.plane_dist)) * 64'sd65536;
      flags = '0;
      flags[FRONT_BIT] = (near_acc >= limit);
      flags[BACK_BIT]  = (far_acc < limit);
      return flags;
    endfunction

    function void note_box(box_t b);
      pending_flags.push_back(classify(b));
    endfunction

    function void check_flags(logic [FLAGS_W-1:0] seen);
      logic [FLAGS_W-1:0] want;
      if (pending_flags.size() == 0) begin
        $display("%0t: result with no item outstanding, expected none actual %b", $time, seen);
        mismatches++;
        return;
      end
      want = pending_flags.pop_front();
      if (seen !== want) begin
        $display("%0t: side_flags mismatch, expected %b actual %b", $time, want, seen);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  box_t               drive_box;
  logic               out_valid;
  logic [FLAGS_W-1:0] out_side_flags;

  side_flag_ledger    ledger = new();
  int                 idle_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  box_plane_side_classifier_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_box_min_x   (drive_box.min_x),
    .in_box_min_y   (drive_box.min_y),
    .in_box_min_z   (drive_box.min_z),
    .in_box_max_x   (drive_box.max_x),
    .in_box_max_y   (drive_box.max_y),
    .in_box_max_z   (drive_box.max_z),
    .in_normal_x    (drive_box.nx),
    .in_normal_y    (drive_box.ny),
    .in_normal_z    (drive_box.nz),
    .in_plane_dist  (drive_box.plane_dist),
    .in_sign_bits   (drive_box.sign_bits),
    .out_valid      (out_valid),
    .out_side_flags (out_side_flags)
  );

  // acceptance and result monitor, plus the watchdog on stalled traffic
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      ledger.note_box(drive_box);
      idle_cycles = 0;
    end else if (rst_n && out_valid) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (rst_n && out_valid) begin
      ledger.check_flags(out_side_flags);
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog, no traffic for %0d cycles", $time, IDLE_LIMIT);
      $display("[box_plane_side_classifier_top] ERROR");
      $finish;
    end
  end

  function automatic box_t make_box(coord_t min_x, coord_t min_y, coord_t min_z,
                                    coord_t max_x, coord_t max_y, coord_t max_z,
                                    normal_t nx, normal_t ny, normal_t nz,
                                    coord_t plane_dist, logic [AXES-1:0] sign_bits);
    box_t b;
    b.min_x = min_x;
    b.min_y = min_y;
    b.min_z = min_z;
    b.max_x = max_x;
    b.max_y = max_y;
    b.max_z = max_z;
    b.nx = nx;
    b.ny = ny;
    b.nz = nz;
    b.plane_dist = plane_dist;
    b.sign_bits = sign_bits;
    return b;
  endfunction

  // mostly sane boxes with the plane close to a corner projection, so both
  // flags flip often and exact ties come up; the rest is broken or raw noise
  function automatic box_t random_box();
    coord_t          lo[AXES];
    coord_t          hi[AXES];
    coord_t          corner;
    coord_t          swap_tmp;
    normal_t         nv[AXES];
    logic [AXES-1:0] sb;
    longint          acc;
    int              mode;
    int              shift;
    mode = $urandom_range(0, 9);
    if (mode >= 8) begin
      for (int i = 0; i < AXES; i++) begin
        lo[i] = coord_t'($urandom);
        hi[i] = coord_t'($urandom);
        nv[i] = normal_t'($urandom);
      end
      return make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], nv[0], nv[1], nv[2],
                      coord_t'($urandom), AXES'($urandom));
    end
    shift = $urandom_range(0, 20);
    acc = 0;
    for (int i = 0; i < AXES; i++) begin
      lo[i] = coord_t'($signed($urandom) >>> shift);
      hi[i] = coord_t'($signed($urandom) >>> shift);
      if (lo[i] > hi[i]) begin
        swap_tmp = lo[i];
        lo[i] = hi[i];
        hi[i] = swap_tmp;
      end
      // broken items: minimum above maximum on some axes
      if (mode == 7 && $urandom_range(0, 1) == 1) begin
        swap_tmp = lo[i];
        lo[i] = hi[i];
        hi[i] = swap_tmp;
      end
      case ($urandom_range(0, 7))
        0: nv[i] = '0;
        1: nv[i] = N_ONE;
        2: nv[i] = -N_ONE;
        default: nv[i] = normal_t'(int'($urandom_range(0, 131072)) - 65536);
      endcase
      sb[i] = (nv[i] < 0);
    end
    if (mode == 7) begin
      sb = AXES'($urandom);
    end
    for (int i = 0; i < AXES; i++) begin
      case ($urandom_range(0, 2))
        0: corner = sb[i] ? lo[i] : hi[i];
        1: corner = sb[i] ? hi[i] : lo[i];
        default: corner = ($urandom_range(0, 1) == 1) ? lo[i] : hi[i];
      endcase
      acc += longint'(nv[i]) * longint'(corner);
    end
    acc = acc >>> FRAC_SHIFT;
    if (mode != 6) begin
      acc = acc + longint'(int'($urandom_range(0, 4)) - 2);
    end
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    return make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], nv[0], nv[1], nv[2],
                    coord_t'(acc), sb);
  endfunction

  // hold the item on the ports until an edge with busy low takes it
  task automatic send_box(box_t b);
    start     <= 1'b1;
    drive_box <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause_input(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    drive_box <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // zero box on a zero plane: the first sum ties the distance
    send_box(make_box(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 3'b000));
    // unit box through the origin under every corner choice
    for (int s = 0; s < 8; s++) begin
      send_box(make_box(-C_ONE, -C_ONE, -C_ONE, C_ONE, C_ONE, C_ONE,
                        N_ONE, -N_ONE, N_ONE, 0, AXES'(s)));
    end
    // extreme coordinates and distances
    send_box(make_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX,
                      N_ONE, N_ONE, N_ONE, C_MAX, 3'b111));
    send_box(make_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX,
                      -N_ONE, -N_ONE, -N_ONE, C_MIN, 3'b000));
    // normals past the unit range, full 18-bit values
    send_box(make_box(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX,
                      N_MAX, N_MIN, N_MAX, C_MIN, 3'b010));
    send_box(make_box(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN,
                      N_MIN, N_MIN, N_MIN, C_MAX, 3'b101));
    // minimum above maximum, used as given
    send_box(make_box(5 * C_ONE, 5 * C_ONE, 5 * C_ONE, -5 * C_ONE, -5 * C_ONE, -5 * C_ONE,
                      N_ONE, N_ONE, N_ONE, 0, 3'b000));
    // box 0..2 on x: ties and one lsb past them
    send_box(make_box(0, 0, 0, 2 * C_ONE, 0, 0, N_ONE, 0, 0, 2 * C_ONE, 3'b000));
    send_box(make_box(0, 0, 0, 2 * C_ONE, 0, 0, N_ONE, 0, 0, 2 * C_ONE + 1, 3'b000));
    send_box(make_box(0, 0, 0, 2 * C_ONE, 0, 0, N_ONE, 0, 0, 0, 3'b000));

    for (int k = 0; k < N_RANDOM; k++) begin
      send_box(random_box());
      if (k < N_RANDOM - CALM_TAIL && $urandom_range(0, 5) == 0) begin
        pause_input($urandom_range(1, 17));
      end
    end
    start <= 1'b0;

    // drain the pipeline; the watchdog catches a result that never comes
    while (ledger.pending_flags.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    if (ledger.mismatches == 0 && ledger.pending_flags.size() == 0) begin
      $display("[box_plane_side_classifier_top] OK");
    end else begin
      $display("[box_plane_side_classifier_top] ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/bpsc_pkg.sv
hdl/box_plane_side_classifier_top.sv
bench/tb_box_plane_side_classifier_top.sv
